>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gpdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpdc_pkg: constants and helpers of the go-to-pose drive controller
// Controller modes, register indexes, angle constants, CORDIC arctangent
// table, register resets and small fixed-point helpers.
// ----------------------------------------------------------------------------
package gpdc_pkg;

    localparam int CORDIC_STEPS_DEF = 16;

    // controller modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ALIGN = 2'd1;
    localparam logic [1:0] MODE_MOVE  = 2'd2;
    localparam logic [1:0] MODE_FINAL = 2'd3;

    // configuration register indexes
    localparam logic [2:0] REG_TURN_GAIN  = 3'd0;
    localparam logic [2:0] REG_TURN_LIM   = 3'd1;
    localparam logic [2:0] REG_FWD_LIM    = 3'd2;
    localparam logic [2:0] REG_REV_LIM    = 3'd3;
    localparam logic [2:0] REG_ARRIVE     = 3'd4;
    localparam logic [2:0] REG_HEAD_TOL   = 3'd5;
    localparam logic [2:0] REG_SLOW       = 3'd6;

    // register reset values
    localparam logic [15:0] RST_TURN_GAIN = 16'd1280;
    localparam logic [14:0] RST_TURN_LIM  = 15'd4096;
    localparam logic [14:0] RST_FWD_LIM   = 15'd3277;
    localparam logic [15:0] RST_REV_LIM   = 16'hF99A;
    localparam logic [15:0] RST_ARRIVE    = 16'd205;
    localparam logic [14:0] RST_HEAD_TOL  = 15'd713;
    localparam logic [14:0] RST_SLOW      = 15'd2048;

    // angles: 1/8192 rad (coarse) and 2^-24 rad (fine)
    localparam int PI_C      = 25736;
    localparam int HALF_PI_C = 12868;
    localparam int TWO_PI_C  = 51472;
    localparam int PI_F      = 52707178;
    localparam int HALF_PI_F = 26353589;
    localparam int TWO_PI_F  = 105414356;

    // 1/K of the CORDIC in Q30
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam int ONE_RAD_Q12 = 4096;

    // heading error width (1/8192 rad)
    localparam int ERR_W = 20;

    // arctangent of 2^-i in 2^-24 rad
    function automatic logic [23:0] atan_at(input logic [4:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

    // one-step wrap of a heading error into about +-pi
    function automatic logic signed [ERR_W-1:0] wrap_once(input logic signed [ERR_W-1:0] e);
        logic signed [ERR_W-1:0] r;
        if (e > ERR_W'(PI_C))       r = e - ERR_W'(TWO_PI_C);
        else if (e < -ERR_W'(PI_C)) r = e + ERR_W'(TWO_PI_C);
        else                        r = e;
        return r;
    endfunction

    // clamp a magnitude to the turn-rate limit and apply the sign
    function automatic logic signed [15:0] rate_clamp(input logic neg,
                                                      input logic [37:0] mag,
                                                      input logic [14:0] lim);
        logic [14:0] m;
        m = (mag > {23'd0, lim}) ? lim : mag[14:0];
        return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

endpackage

>>> rtl/goto_pose_drive_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goto_pose_drive_controller_unit: go-to-pose controller, differential drive
// Align, pure-pursuit move and final rotate on one shared CORDIC stage,
// one shared multiplier and a radix-2 divider under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//  - Input stream: tuser is kind (0 goal, 1 tick), tdata carries the pose.
//    A goal beat stores the target and enters align mode; it gives no result.
//    A tick beat gives one command beat on the output stream.
//  - Config channel: index and data, always ready; the user must write it
//    only while idle, as the block itself does not enforce this.
//  - Work per tick: an idle tick only loads the output; a final-mode
//    tick adds a multiply; an align tick runs the CORDIC iterations (one
//    per cycle); a move tick runs them twice, then the 38-step division loop.
//  - One item is in work at a time; the input is not ready until the
//    command sits in the output register.
//  - A stalled receiver holds the command in the output register; the
//    next item may be taken and computed meanwhile, and waits for the slot.
//  - Reset (synchronous, active low) sets idle mode, clears the target and
//    loads the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module goto_pose_drive_controller_unit #(
    parameter int CORDIC_STEPS = gpdc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // pos_x[23:0], pos_y[47:24], heading[63:48]
    input  logic        i_s_axis_tuser,   // kind
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // linear_speed[15:0], turn_rate[31:16]
    output logic [2:0]  o_m_axis_tuser,   // mode_now[1:0], reversing[2]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int XW    = 34;
    localparam int ZW    = 30;
    localparam int IW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DW    = 26;
    localparam int DIV_N = 38;
    localparam int EW    = gpdc_pkg::ERR_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ITER  = 4'd1;
    localparam logic [3:0] S_DLO   = 4'd2;
    localparam logic [3:0] S_DHI   = 4'd3;
    localparam logic [3:0] S_DIST  = 4'd4;
    localparam logic [3:0] S_ADEC1 = 4'd5;
    localparam logic [3:0] S_ADEC2 = 4'd6;
    localparam logic [3:0] S_MDEC  = 4'd7;
    localparam logic [3:0] S_SPEED = 4'd8;
    localparam logic [3:0] S_WRAP  = 4'd9;
    localparam logic [3:0] S_MUL1  = 4'd10;
    localparam logic [3:0] S_MUL2  = 4'd11;
    localparam logic [3:0] S_DIV   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;
    localparam logic [3:0] S_FIN2  = 4'd14;
    localparam logic [3:0] S_OUT   = 4'd15;

    // configuration registers
    logic [15:0] r_gain;
    logic [14:0] r_turn_lim;
    logic [14:0] r_fwd_lim;
    logic [15:0] r_rev_lim;
    logic [15:0] r_arrive;
    logic [14:0] r_tol;
    logic [14:0] r_slow;

    // controller state
    logic [3:0]  r_state;
    logic [1:0]  r_mode;
    logic        r_bflag;
    logic [23:0] r_tx;
    logic [23:0] r_ty;
    logic [15:0] r_th;
    logic signed [15:0] r_hd;

    // working registers
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_vec;
    logic [IW-1:0]        r_i;
    logic [63:0]          r_acc;
    logic [DW-1:0]        r_dist;
    logic signed [EW-1:0] r_err;
    logic signed [15:0]   r_v;
    logic signed [15:0]   r_w;
    logic                 r_neg;
    logic [37:0]          r_num;
    logic [DW:0]          r_rem;
    logic [37:0]          r_q;
    logic [5:0]           r_k;

    // output register
    logic        r_ovalid;
    logic [15:0] r_ospeed;
    logic [15:0] r_orate;
    logic [1:0]  r_omode;
    logic        r_orev;

    logic        in_acc;
    logic signed [23:0] in_px;
    logic signed [23:0] in_py;
    logic signed [15:0] in_hd;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [XW-1:0] x0;
    logic signed [XW-1:0] y0;

    logic signed [XW-1:0] sh_x;
    logic signed [XW-1:0] sh_y;
    logic signed [ZW-1:0] atn;
    logic                 rot_pos;

    logic [46:0] mul_a;
    logic [15:0] mul_b;
    logic [62:0] prod;

    logic signed [18:0]   td;
    logic signed [EW-1:0] hd_e;
    logic signed [EW-1:0] yaw_e;
    logic signed [EW-1:0] err_a;
    logic signed [EW-1:0] err_f;
    logic signed [EW-1:0] tol_e;
    logic [EW-1:0]        err_f_mag;
    logic [30:0]          s_mag;
    logic [15:0]          v_mag;
    logic [28:0]          m_val;
    logic signed [29:0]   neg_m;
    logic signed [29:0]   rev_s;
    logic [DW:0]          trial;
    logic                 qbit;
    logic [37:0]          q_next;
    logic [63:0]          dist_sum;

    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign in_px  = $signed(i_s_axis_tdata[23:0]);
    assign in_py  = $signed(i_s_axis_tdata[47:24]);
    assign in_hd  = $signed(i_s_axis_tdata[63:48]);

    // goal offset and CORDIC seed; the left half-plane is folded over when loaded
    assign dx = $signed({r_tx[23], r_tx}) - $signed({in_px[23], in_px});
    assign dy = $signed({r_ty[23], r_ty}) - $signed({in_py[23], in_py});
    assign x0 = $signed({{3{dx[24]}}, dx, 6'b0});
    assign y0 = $signed({{3{dy[24]}}, dy, 6'b0});

    // shared CORDIC micro-rotation
    assign sh_x    = r_x >>> r_i;
    assign sh_y    = r_y >>> r_i;
    assign atn     = $signed({{(ZW-24){1'b0}}, gpdc_pkg::atan_at(5'(r_i))});
    assign rot_pos = r_vec ? !(r_y > 0) : (r_z >= 0);

    // heading arithmetic
    assign td    = 19'((r_z + ZW'(1024)) >>> 11);
    assign hd_e  = EW'(r_hd);
    assign yaw_e = (r_hd > 0) ? hd_e - EW'(gpdc_pkg::PI_C)
                 : (r_hd < 0) ? hd_e + EW'(gpdc_pkg::PI_C) : hd_e;
    assign tol_e = $signed({{(EW-15){1'b0}}, r_tol});
    assign err_a = gpdc_pkg::wrap_once(EW'(td) - yaw_e);
    assign err_f = gpdc_pkg::wrap_once($signed(EW'($signed(r_th))) - hd_e);
    assign err_f_mag = err_f[EW-1] ? EW'(-err_f) : EW'(err_f);

    assign s_mag = r_y[XW-1] ? 31'(-r_y) : 31'(r_y);
    assign v_mag = r_v[15] ? 16'(-r_v) : 16'(r_v);
    assign m_val = r_acc[40:12];

    // reverse speed candidate and its limit, both signed
    assign neg_m = -$signed({1'b0, m_val});
    assign rev_s = $signed({{14{r_rev_lim[15]}}, r_rev_lim});

    // divider step
    assign trial  = {r_rem[DW-1:0], r_num[37]};
    assign qbit   = (trial >= {1'b0, r_dist});
    assign q_next = {r_q[36:0], qbit};

    assign dist_sum = r_acc + (64'd1 << 35);

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DLO: begin
                mul_a = 47'(r_x[31:0]);
                mul_b = gpdc_pkg::INV_GAIN_Q30[15:0];
            end
            S_DHI: begin
                mul_a = 47'(r_x[31:0]);
                mul_b = {2'b0, gpdc_pkg::INV_GAIN_Q30[29:16]};
            end
            S_MDEC: begin
                mul_a = 47'(r_dist);
                mul_b = {1'b0, r_slow};
            end
            S_MUL1: begin
                mul_a = 47'(s_mag);
                mul_b = v_mag;
            end
            S_MUL2: begin
                mul_a = r_acc[46:0];
                mul_b = r_gain;
            end
            S_FIN: begin
                mul_a = 47'(err_f_mag);
                mul_b = r_gain;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 63'(mul_a) * 63'(mul_b);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= gpdc_pkg::RST_TURN_GAIN;
            r_turn_lim <= gpdc_pkg::RST_TURN_LIM;
            r_fwd_lim  <= gpdc_pkg::RST_FWD_LIM;
            r_rev_lim  <= gpdc_pkg::RST_REV_LIM;
            r_arrive   <= gpdc_pkg::RST_ARRIVE;
            r_tol      <= gpdc_pkg::RST_HEAD_TOL;
            r_slow     <= gpdc_pkg::RST_SLOW;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gpdc_pkg::REG_TURN_GAIN: r_gain     <= i_cfg_data;
                gpdc_pkg::REG_TURN_LIM:  r_turn_lim <= i_cfg_data[14:0];
                gpdc_pkg::REG_FWD_LIM:   r_fwd_lim  <= i_cfg_data[14:0];
                gpdc_pkg::REG_REV_LIM:   r_rev_lim  <= i_cfg_data;
                gpdc_pkg::REG_ARRIVE:    r_arrive   <= i_cfg_data;
                gpdc_pkg::REG_HEAD_TOL:  r_tol      <= i_cfg_data[14:0];
                gpdc_pkg::REG_SLOW:      r_slow     <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= gpdc_pkg::MODE_IDLE;
            r_bflag  <= 1'b0;
            r_tx     <= '0;
            r_ty     <= '0;
            r_th     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop the result once taken, unless a new one is loaded now
            if (r_ovalid && i_m_axis_tready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_hd <= in_hd;
                        r_v  <= '0;
                        r_w  <= '0;
                        if (!i_s_axis_tuser) begin
                            // store goal, no result
                            r_tx    <= i_s_axis_tdata[23:0];
                            r_ty    <= i_s_axis_tdata[47:24];
                            r_th    <= i_s_axis_tdata[63:48];
                            r_bflag <= 1'b0;
                            r_mode  <= gpdc_pkg::MODE_ALIGN;
                        end else if (r_mode == gpdc_pkg::MODE_IDLE) begin
                            r_state <= S_OUT;
                        end else if (r_mode == gpdc_pkg::MODE_FINAL) begin
                            r_state <= S_FIN;
                        end else if (dx == 0 && dy == 0) begin
                            r_z     <= '0;
                            r_dist  <= '0;
                            r_state <= (r_mode == gpdc_pkg::MODE_ALIGN) ? S_ADEC1 : S_MDEC;
                        end else begin
                            r_vec <= 1'b1;
                            r_i   <= '0;
                            if (x0 < 0) begin
                                r_x <= -x0;
                                r_y <= -y0;
                                r_z <= (y0 >= 0) ? ZW'(gpdc_pkg::PI_F) : -ZW'(gpdc_pkg::PI_F);
                            end else begin
                                r_x <= x0;
                                r_y <= y0;
                                r_z <= '0;
                            end
                            r_state <= S_ITER;
                        end
                    end
                end
                S_ITER: begin
                    if (rot_pos) begin
                        r_x <= r_x - sh_y;
                        r_y <= r_y + sh_x;
                        r_z <= r_z - atn;
                    end else begin
                        r_x <= r_x + sh_y;
                        r_y <= r_y - sh_x;
                        r_z <= r_z + atn;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == IW'(CORDIC_STEPS - 1)) begin
                        r_state <= r_vec ? S_DLO : S_MUL1;
                    end
                end
                // scale the vector length by 1/K in two partial products
                S_DLO: begin
                    r_acc   <= 64'(prod);
                    r_state <= S_DHI;
                end
                S_DHI: begin
                    r_acc   <= r_acc + (64'(prod) << 16);
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_dist  <= dist_sum[36+DW-1:36];
                    r_state <= (r_mode == gpdc_pkg::MODE_ALIGN) ? S_ADEC1 : S_MDEC;
                end
                S_ADEC1: begin
                    r_err   <= gpdc_pkg::wrap_once(EW'(td) - hd_e);
                    r_state <= S_ADEC2;
                end
                S_ADEC2: begin
                    // flip to reverse when the goal lies behind
                    if (r_err > EW'(gpdc_pkg::HALF_PI_C) || r_err < -EW'(gpdc_pkg::HALF_PI_C)) begin
                        r_bflag <= 1'b1;
                        if (err_a > tol_e || err_a < -tol_e) begin
                            r_w <= (err_a > 0) ? 16'(gpdc_pkg::ONE_RAD_Q12)
                                               : -16'(gpdc_pkg::ONE_RAD_Q12);
                        end else begin
                            r_mode <= gpdc_pkg::MODE_MOVE;
                        end
                    end else begin
                        r_bflag <= 1'b0;
                        if (r_err > tol_e || r_err < -tol_e) begin
                            r_w <= (r_err > 0) ? 16'(gpdc_pkg::ONE_RAD_Q12)
                                               : -16'(gpdc_pkg::ONE_RAD_Q12);
                        end else begin
                            r_mode <= gpdc_pkg::MODE_MOVE;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_MDEC: begin
                    if (r_dist == 0 || r_dist < DW'(r_arrive)) begin
                        r_mode  <= gpdc_pkg::MODE_FINAL;
                        r_state <= S_OUT;
                    end else begin
                        r_acc   <= 64'(prod);
                        r_state <= S_SPEED;
                    end
                end
                S_SPEED: begin
                    // speed scales with distance, clamped by the limits
                    if (r_bflag) begin
                        r_v <= (neg_m < rev_s) ? $signed(r_rev_lim) : neg_m[15:0];
                    end else begin
                        r_v <= (m_val > 29'(r_fwd_lim)) ? $signed({1'b0, r_fwd_lim})
                                                        : $signed({1'b0, m_val[14:0]});
                    end
                    r_z     <= r_z - $signed({{(ZW-27){r_hd[15]}}, r_hd, 11'b0});
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    // bring the angle into +-pi, fold to +-pi/2, seed the sine
                    if (r_z > ZW'(gpdc_pkg::PI_F)) begin
                        r_z <= r_z - ZW'(gpdc_pkg::TWO_PI_F);
                    end else if (r_z < -ZW'(gpdc_pkg::PI_F)) begin
                        r_z <= r_z + ZW'(gpdc_pkg::TWO_PI_F);
                    end else begin
                        if (r_z > ZW'(gpdc_pkg::HALF_PI_F)) begin
                            r_z <= ZW'(gpdc_pkg::PI_F) - r_z;
                        end else if (r_z < -ZW'(gpdc_pkg::HALF_PI_F)) begin
                            r_z <= -ZW'(gpdc_pkg::PI_F) - r_z;
                        end
                        r_x     <= $signed(XW'(gpdc_pkg::INV_GAIN_Q30));
                        r_y     <= '0;
                        r_vec   <= 1'b0;
                        r_i     <= '0;
                        r_state <= S_ITER;
                    end
                end
                S_MUL1: begin
                    r_neg   <= r_y[XW-1] != r_v[15];
                    r_acc   <= 64'(prod);
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_acc   <= 64'(prod);
                    r_num   <= prod[62:25];
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_k     <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit a cycle
                    r_rem <= qbit ? trial - {1'b0, r_dist} : trial;
                    r_num <= {r_num[36:0], 1'b0};
                    r_q   <= q_next;
                    r_k   <= r_k + 1'b1;
                    if (r_k == 6'(DIV_N - 1)) begin
                        r_w     <= gpdc_pkg::rate_clamp(r_neg, q_next, r_turn_lim);
                        r_state <= S_OUT;
                    end
                end
                S_FIN: begin
                    if (err_f < tol_e && err_f > -tol_e) begin
                        r_mode  <= gpdc_pkg::MODE_IDLE;
                        r_state <= S_OUT;
                    end else begin
                        r_neg   <= err_f[EW-1];
                        r_acc   <= 64'(prod);
                        r_state <= S_FIN2;
                    end
                end
                S_FIN2: begin
                    r_w     <= gpdc_pkg::rate_clamp(r_neg, {14'd0, r_acc[32:9]}, r_turn_lim);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // wait for the output slot, then load the command beat
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ospeed <= r_v;
                        r_orate  <= r_w;
                        r_omode  <= r_mode;
                        r_orev   <= r_bflag;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_orate, r_ospeed};
    assign o_m_axis_tuser  = {r_orev, r_omode};

    // checks
    `ASSERT_NEXT(a_goal_aligns, in_acc && !i_s_axis_tuser,
                 r_mode == gpdc_pkg::MODE_ALIGN && !r_bflag, "goal did not enter align")
    `ASSERT_IMPL(a_speed_in_move, o_m_axis_tvalid && o_m_axis_tdata[15:0] != 16'd0,
                 o_m_axis_tuser[1:0] == gpdc_pkg::MODE_MOVE, "speed outside move mode")
    `ASSERT_NEXT(a_out_loaded, r_state == S_OUT && !r_ovalid,
                 o_m_axis_tvalid, "free output slot not loaded")

endmodule
